// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds request codes, cursor operation codes and the controller/datapath structs.
// Depends on nothing.
package tcw_pkg;

  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Cursor update operations issued by the controller.
  localparam logic [2:0] CUR_HOLD      = 3'd0;
  localparam logic [2:0] CUR_ADVANCE   = 3'd1;
  localparam logic [2:0] CUR_NEWLINE   = 3'd2;
  localparam logic [2:0] CUR_WRAP_LAST = 3'd3;
  localparam logic [2:0] CUR_SET       = 3'd4;
  localparam logic [2:0] CUR_HOME      = 3'd5;

  typedef struct packed {
    logic [2:0] cur_op;
    logic       put_wr;
    logic       rd_at_pos;
    logic       sweep_fill;
    logic       fill_blank;
    logic       sweep_scroll;
    logic       out_load;
    logic       out_scrolled;
    logic       out_is_read;
  } tcw_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic cur_at_end;
    logic cur_last_row;
    logic slot_free;
  } tcw_status_t;

endpackage

// ===== src/tcw_datapath.sv =====
// Datapath of the text console writer: screen store, cursor, sweep counter,
// configuration register and result register.
// Depends on tcw_pkg.
module tcw_datapath #(
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  localparam int ColW = $clog2(SCREEN_COLS),
  localparam int RowW = $clog2(SCREEN_ROWS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcw_pkg::tcw_cmd_t         cmd_i,
  output tcw_pkg::tcw_status_t      sts_o,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute_i,
  input  logic [ColW-1:0]           col_i,
  input  logic [RowW-1:0]           row_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ColW-1:0]           cursor_col_o,
  output logic [RowW-1:0]           cursor_row_o,
  output logic                      scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr_o
);

  localparam int CellCount = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW = $clog2(CellCount);
  localparam logic [AW-1:0] LastAddr    = AW'(CellCount - 1);
  localparam logic [AW-1:0] LastRowAddr = AW'(CellCount - SCREEN_COLS);
  localparam logic [AW-1:0] ColsA       = AW'(SCREEN_COLS);
  localparam logic [ColW-1:0] LastCol   = ColW'(SCREEN_COLS - 1);
  localparam logic [RowW-1:0] LastRow   = RowW'(SCREEN_ROWS - 1);

  logic [tcw_pkg::CELL_W-1:0] mem [CellCount];
  logic [tcw_pkg::CELL_W-1:0] rd_data_q;

  logic [ColW-1:0] cur_col_q, cur_col_d;
  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic [AW-1:0]   cur_addr_q, cur_addr_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [tcw_pkg::ATTR_W-1:0] def_attr_q;

  logic            pend_q, pend_zero_q;
  logic [AW-1:0]   pend_addr_q;

  logic [ColW-1:0] col_c;
  logic [RowW-1:0] row_c;
  logic [AW-1:0]   pos_addr;

  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;

  logic            out_valid_q;
  logic [ColW-1:0] out_col_q;
  logic [RowW-1:0] out_row_q;
  logic            out_scr_q;
  logic [tcw_pkg::CELL_W-1:0] out_cell_q;

  // Saturate the requested position onto the screen.
  always_comb begin
    col_c = ({1'b0, col_i} >= (ColW+1)'(SCREEN_COLS)) ? LastCol : col_i;
    row_c = ({1'b0, row_i} >= (RowW+1)'(SCREEN_ROWS)) ? LastRow : row_i;
    pos_addr = AW'(row_c) * ColsA + AW'(col_c);
  end

  always_comb begin
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    cur_addr_d = cur_addr_q;
    case (cmd_i.cur_op)
      tcw_pkg::CUR_ADVANCE: begin
        cur_addr_d = cur_addr_q + AW'(1);
        if (cur_col_q == LastCol) begin
          cur_col_d = '0;
          cur_row_d = cur_row_q + RowW'(1);
        end else begin
          cur_col_d = cur_col_q + ColW'(1);
        end
      end
      tcw_pkg::CUR_NEWLINE: begin
        cur_addr_d = cur_addr_q - AW'(cur_col_q) + ColsA;
        cur_col_d  = '0;
        cur_row_d  = cur_row_q + RowW'(1);
      end
      tcw_pkg::CUR_WRAP_LAST: begin
        cur_addr_d = LastRowAddr;
        cur_col_d  = '0;
        cur_row_d  = LastRow;
      end
      tcw_pkg::CUR_SET: begin
        cur_addr_d = pos_addr;
        cur_col_d  = col_c;
        cur_row_d  = row_c;
      end
      tcw_pkg::CUR_HOME: begin
        cur_addr_d = '0;
        cur_col_d  = '0;
        cur_row_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.sweep_fill || cmd_i.sweep_scroll) begin
      cnt_d = (cnt_q == LastAddr) ? '0 : cnt_q + AW'(1);
    end
  end

  // One write port and one read port per cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr_q;
    wr_data = {attribute_i, char_code_i};
    if (pend_q) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_q;
      wr_data = pend_zero_q ? {rd_data_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W],
                               {tcw_pkg::CHAR_W{1'b0}}} : rd_data_q;
    end else if (cmd_i.sweep_fill) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = cmd_i.fill_blank ? {def_attr_q, tcw_pkg::BLANK_CODE} : '0;
    end else if (cmd_i.put_wr) begin
      wr_en = 1'b1;
    end
    rd_en   = cmd_i.sweep_scroll || cmd_i.rd_at_pos;
    rd_addr = pos_addr;
    if (cmd_i.sweep_scroll) begin
      rd_addr = (cnt_q < LastRowAddr) ? cnt_q + ColsA : cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      cur_addr_q  <= '0;
      cnt_q       <= '0;
      def_attr_q  <= tcw_pkg::ATTR_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      cur_addr_q <= cur_addr_d;
      cnt_q      <= cnt_d;
      pend_q     <= cmd_i.sweep_scroll;
      if (cfg_valid_i) begin
        def_attr_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_scroll) begin
      pend_addr_q <= cnt_q;
      pend_zero_q <= (cnt_q >= LastRowAddr);
    end
    if (cmd_i.out_load) begin
      out_col_q  <= cur_col_d;
      out_row_q  <= cur_row_d;
      out_scr_q  <= cmd_i.out_scrolled;
      out_cell_q <= cmd_i.out_is_read ? rd_data_q : '0;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign scrolled_o   = out_scr_q;
  assign cell_char_o  = out_cell_q[tcw_pkg::CHAR_W-1:0];
  assign cell_attr_o  = out_cell_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];

  assign sts_o.sweep_last   = (cnt_q == LastAddr);
  assign sts_o.cur_at_end   = (cur_addr_q == LastAddr);
  assign sts_o.cur_last_row = (cur_row_q == LastRow);
  assign sts_o.slot_free    = !out_valid_q || !out_stall_i;

  // The cursor must always address a cell on the screen.
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < (ColW+1)'(SCREEN_COLS)) &&
    ({1'b0, cur_row_q} < (RowW+1)'(SCREEN_ROWS)))
    else $error("cursor left the screen");

  // The linear address tracks the column and row.
  a_cursor_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_addr_q == AW'(cur_row_q) * ColsA + AW'(cur_col_q))
    else $error("cursor address out of step with column and row");

  // A pending scroll copy never competes with a character write.
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !cmd_i.put_wr && !cmd_i.sweep_fill)
    else $error("scroll copy collides with another write");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.out_load)
    else $error("result register overwritten");

endmodule

// ===== src/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Decodes requests and sequences the clearing and scrolling sweeps.
// Depends on tcw_pkg.
module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  tcw_pkg::tcw_status_t sts_i,
  output tcw_pkg::tcw_cmd_t    cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       scr_q, scr_d;
  logic       rd_q, rd_d;
  logic       is_nl;

  assign is_nl = (char_code_i == tcw_pkg::NEWLINE_CODE);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    scr_d      = scr_q;
    rd_d       = rd_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_fill = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = !sts_i.slot_free;
        if (in_valid_i && sts_i.slot_free) begin
          scr_d = 1'b0;
          rd_d  = 1'b0;
          case (req_type_i)
            tcw_pkg::REQ_PUT: begin
              cmd_o.put_wr = !is_nl;
              if ((is_nl && sts_i.cur_last_row) || (!is_nl && sts_i.cur_at_end)) begin
                cmd_o.cur_op = tcw_pkg::CUR_WRAP_LAST;
                scr_d        = 1'b1;
                state_d      = ST_SCROLL;
              end else begin
                cmd_o.cur_op   = is_nl ? tcw_pkg::CUR_NEWLINE : tcw_pkg::CUR_ADVANCE;
                cmd_o.out_load = 1'b1;
              end
            end
            tcw_pkg::REQ_SET: begin
              cmd_o.cur_op   = tcw_pkg::CUR_SET;
              cmd_o.out_load = 1'b1;
            end
            tcw_pkg::REQ_CLEAR: begin
              cmd_o.cur_op = tcw_pkg::CUR_HOME;
              state_d      = ST_CLEAR;
            end
            tcw_pkg::REQ_READ: begin
              cmd_o.rd_at_pos = 1'b1;
              rd_d            = 1'b1;
              state_d         = ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep_fill = 1'b1;
        cmd_o.fill_blank = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd_o.sweep_scroll = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_scrolled = scr_q;
          cmd_o.out_is_read  = rd_q;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      scr_q   <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      scr_q   <= scr_d;
      rd_q    <= rd_d;
    end
  end

  // The power-up clearing pass runs to its end before any request is taken.
  a_init_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT && !sts_i.sweep_last) |=> state_q == ST_INIT)
    else $error("clearing pass ended early");

  // Requests are only taken while idle.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("request taken while busy");

  // A scroll always ends with a result that reports it.
  a_scroll_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL) |-> scr_q && !rd_q)
    else $error("scroll without scroll flag");

endmodule

// ===== src/text_console_writer_top.sv =====
// Top level of the text console writer: text screen store with a linear cursor.
// Instantiates tcw_ctrl and tcw_datapath; depends on tcw_pkg.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o   req_type, char_code, attribute, col, row
//   out      output     out_valid_o / out_stall_i cursor_col, cursor_row, scrolled,
//                                                 cell_char, cell_attr
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (default attribute)
//
// A character put, a newline and a cursor set that do not scroll load their result straight
// from the idle state, so such requests can follow each other back to back while the result
// register is free. A cell read passes through the registered read of the screen store
// before its result is loaded. A clear and a put that scrolls walk the whole store through
// the single write port of the screen store, one cell per cycle, before their result is loaded.
// After reset a clearing pass over all SCREEN_COLS*SCREEN_ROWS cells zeroes
// the store; input is stalled during it, while configuration writes are taken at any time.
// A result waits in the output register while out_stall_i is high; a new request is taken
// only when that register is empty or being emptied in the same cycle.
module text_console_writer_top #(
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  localparam int ColW = $clog2(SCREEN_COLS),
  localparam int RowW = $clog2(SCREEN_ROWS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request channel.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute_i,
  input  logic [ColW-1:0]            col_i,
  input  logic [RowW-1:0]            row_i,
  // Result channel.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ColW-1:0]            cursor_col_o,
  output logic [RowW-1:0]            cursor_row_o,
  output logic                       scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr_o,
  // Configuration channel: the default attribute used by clear.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i
);

  // The controller only sees request decode inputs and datapath status; the screen
  // store, the cursor and the result register live in the datapath.
  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .char_code_i(char_code_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_code_i (char_code_i),
    .attribute_i (attribute_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o),
    .cell_char_o (cell_char_o),
    .cell_attr_o (cell_attr_o)
  );

endmodule

// ===== dv/console_mirror_pkg.sv =====
// Scoreboard for the text console writer testbench: a mirror of the screen store and cursor.
// It predicts each result from the accepted requests and checks the returned ones.
// Depends on tcw_pkg.
package console_mirror_pkg;
  import tcw_pkg::*;

  localparam int COLS = DEF_SCREEN_COLS;
  localparam int ROWS = DEF_SCREEN_ROWS;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS);

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } console_resp_t;

  class console_mirror;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       cursor;
    logic [ATTR_W-1:0] clear_attr;
    console_resp_t     pending [$];
    int unsigned       results_seen;
    int unsigned       mismatches;

    function new();
      int unsigned i;
      for (i = 0; i < CELL_COUNT; i++) cells[i] = '0;
      cursor       = 0;
      clear_attr   = ATTR_RESET;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void set_clear_attr(logic [ATTR_W-1:0] value);
      clear_attr = value;
    endfunction

    // Out-of-range coordinates saturate to the last column and the last row.
    function int unsigned cell_index(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
      int unsigned cc;
      int unsigned rr;
      cc = (c >= COLS) ? COLS - 1 : c;
      rr = (r >= ROWS) ? ROWS - 1 : r;
      return rr * COLS + cc;
    endfunction

    function string describe(console_resp_t r);
      return $sformatf("col=%0d row=%0d scrolled=%0d char=%02h attr=%02h",
                       r.cursor_col, r.cursor_row, r.scrolled, r.cell_char, r.cell_attr);
    endfunction

    // Applies one accepted request to the mirror and queues the result it must produce.
    function void note_request(console_req_t rq);
      console_resp_t     want;
      int unsigned       pos;
      int unsigned       i;
      logic [CELL_W-1:0] cell_word;
      want = '0;
      if (cursor >= CELL_COUNT) cursor = 0;
      case (rq.req_type)
        REQ_PUT: begin
          pos = cursor;
          if (rq.char_code == NEWLINE_CODE) begin
            pos = (pos / COLS) * COLS + COLS - 1;
          end else begin
            cells[pos] = {rq.attr, rq.char_code};
          end
          pos++;
          if (pos >= CELL_COUNT) begin
            for (i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
            for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++) cells[i][CHAR_W-1:0] = '0;
            pos -= COLS;
            want.scrolled = 1'b1;
          end
          cursor = pos;
        end
        REQ_SET: begin
          cursor = cell_index(rq.col, rq.row);
        end
        REQ_CLEAR: begin
          for (i = 0; i < CELL_COUNT; i++) cells[i] = {clear_attr, BLANK_CODE};
          cursor = 0;
        end
        default: begin
          cell_word = cells[cell_index(rq.col, rq.row)];
          want.cell_char = cell_word[CHAR_W-1:0];
          want.cell_attr = cell_word[CELL_W-1:CHAR_W];
        end
      endcase
      want.cursor_col = COL_W'(cursor % COLS);
      want.cursor_row = ROW_W'(cursor / COLS);
      pending.push_back(want);
    endfunction

    function void check_result(console_resp_t got);
      console_resp_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[tb] unexpected result: %s", describe(got));
        return;
      end
      want = pending.pop_front();
      if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
          got.scrolled !== want.scrolled || got.cell_char !== want.cell_char ||
          got.cell_attr !== want.cell_attr) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[tb] result %0d mismatch: expected %s, got %s",
                   results_seen, describe(want), describe(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== dv/text_console_writer_top_tb.sv =====
// Testbench for text_console_writer_top: directed and random console requests with random
// idling on both channels, checked against the scoreboard in console_mirror_pkg.
// Depends on tcw_pkg, console_mirror_pkg and the block's RTL.
module text_console_writer_top_tb;
  import tcw_pkg::*;
  import console_mirror_pkg::*;

  // A clear or a scroll walks all 2000 cells. CYCLE_LIMIT leaves room even if every one of
  // the roughly thousand requests cleared or scrolled, with stalls included.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic [CHAR_W-1:0] char_code_i;
  logic [ATTR_W-1:0] attribute_i;
  logic [COL_W-1:0]  col_i;
  logic [ROW_W-1:0]  row_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [COL_W-1:0]  cursor_col_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic              scrolled_o;
  logic [CHAR_W-1:0] cell_char_o;
  logic [ATTR_W-1:0] cell_attr_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i;

  console_mirror sb = new();

  // Remaining transactions in the sender's current burst; zero starts a gap.
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  text_console_writer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .attribute_i (attribute_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o),
    .cell_char_o (cell_char_o),
    .cell_attr_o (cell_attr_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run guard: a hang anywhere in the block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[text_console_writer_top] ERROR");
      $finish;
    end
  end

  // Every result transaction is handed to the scoreboard at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({cursor_col_o, cursor_row_o, scrolled_o, cell_char_o, cell_attr_o});
    end
  end

  // Receiver stall pattern. It switches at random between no stalls, sparse stalls,
  // alternating stalls and heavy stalls. Once, after 400 results, it holds the stall high
  // without a break while the sender keeps offering requests, so the output register fills
  // and the block has to stall its request channel.
  initial begin : result_stall_gen
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    bit          hold_done;
    mode      = 0;
    span      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sb.results_seen >= 400) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 96);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ~out_stall_i;
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic console_req_t make_req(logic [1:0] kind, logic [CHAR_W-1:0] ch,
                                            logic [ATTR_W-1:0] attr, logic [COL_W-1:0] c,
                                            logic [ROW_W-1:0] r);
    console_req_t rq;
    rq.req_type  = kind;
    rq.char_code = ch;
    rq.attr      = attr;
    rq.col       = c;
    rq.row       = r;
    return rq;
  endfunction

  // Offers one request and returns at the edge where it is taken. The sender works in
  // bursts, and valid drops between bursts. Some bursts are long enough
  // to give stretches with no idling at all. Valid stays high from one request to the
  // next inside a burst, so it is never dropped and raised in the same step.
  task automatic send_request(input console_req_t rq);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rq.req_type;
    char_code_i <= rq.char_code;
    attribute_i <= rq.attr;
    col_i       <= rq.col;
    row_i       <= rq.row;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(rq);
    burst_left--;
  endtask

  // The sender pauses until the block has returned every expected result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Writes the attribute used by clear. Only called while nothing is pending.
  task automatic write_clear_attr(input logic [ATTR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_clear_attr(value);
  endtask

  // Random traffic built mostly from well-formed pieces: a line of text (cursor placed,
  // often on the last row so that overflow and newlines scroll, then a run of puts),
  // read-backs around the cursor row where text was just written, and some noise with
  // every field fully random, coordinates out of range included. Clears are kept rare
  // because each one walks the whole store.
  task automatic run_traffic(input int unsigned count);
    int unsigned  sent;
    int unsigned  len;
    int unsigned  n;
    int unsigned  cur_row;
    console_req_t rq;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          rq = make_req(REQ_SET, CHAR_W'($urandom_range(0, 255)),
                        ATTR_W'($urandom_range(0, 255)),
                        COL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(60, COLS - 1)
                                                           : $urandom_range(0, COLS - 1)),
                        ROW_W'(($urandom_range(0, 9) < 3) ? ROWS - 1
                                                          : $urandom_range(0, ROWS - 1)));
          send_request(rq);
          sent++;
          len = $urandom_range(1, 24);
          for (n = 0; n < len; n++) begin
            rq = make_req(REQ_PUT,
                          ($urandom_range(0, 11) == 0) ? NEWLINE_CODE
                                                       : CHAR_W'($urandom_range(0, 255)),
                          ATTR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                          ROW_W'($urandom_range(0, 31)));
            send_request(rq);
            sent++;
          end
        end
        5, 6, 7: begin
          len = $urandom_range(1, 6);
          for (n = 0; n < len; n++) begin
            cur_row = sb.cursor / COLS;
            rq = make_req(REQ_READ, CHAR_W'($urandom_range(0, 255)),
                          ATTR_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(0, COLS - 1)),
                          ROW_W'(($urandom_range(0, 1) == 0 || cur_row == 0) ? cur_row
                                                                             : cur_row - 1));
            send_request(rq);
            sent++;
          end
        end
        default: begin
          rq = make_req(2'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                        ATTR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                        ROW_W'($urandom_range(0, 31)));
          if (rq.req_type == REQ_CLEAR && $urandom_range(0, 3) != 0) rq.req_type = REQ_READ;
          send_request(rq);
          sent++;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned       phase;
    logic [ATTR_W-1:0] attr_value;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_PUT;
    char_code_i <= '0;
    attribute_i <= '0;
    col_i       <= '0;
    row_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block runs a clearing pass after reset and stalls requests meanwhile; the
    // configuration write is taken during that pass.
    write_clear_attr(8'h00);

    // Directed part. A read right after reset sees a zeroed cell; puts cover the
    // extremes of character and attribute; a newline must not write its cell.
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_request(make_req(REQ_PUT, 8'h41, 8'hFF, 7'd0, 5'd0));
    send_request(make_req(REQ_PUT, 8'h00, 8'h00, 7'd127, 5'd31));
    send_request(make_req(REQ_PUT, 8'hFF, 8'hFF, 7'd0, 5'd0));
    send_request(make_req(REQ_PUT, NEWLINE_CODE, 8'hFF, 7'd0, 5'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd2, 5'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd3, 5'd0));
    // Out-of-range coordinates saturate to the last cell; a put there scrolls, moves the
    // cell up one row and leaves only the attribute behind on the last row.
    send_request(make_req(REQ_SET, 8'h00, 8'h00, 7'd127, 5'd31));
    send_request(make_req(REQ_PUT, 8'h5A, 8'h1E, 7'd0, 5'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd23));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    // A newline on the last row wraps past the end and scrolls as well.
    send_request(make_req(REQ_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0));
    send_request(make_req(REQ_SET, 8'h00, 8'h00, 7'd79, 5'd24));
    send_request(make_req(REQ_SET, 8'h00, 8'h00, 7'd80, 5'd25));
    send_request(make_req(REQ_SET, 8'h00, 8'h00, 7'd0, 5'd24));
    send_request(make_req(REQ_PUT, 8'h55, 8'hAA, 7'd0, 5'd0));
    send_request(make_req(REQ_PUT, 8'hAA, 8'h55, 7'd0, 5'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd1, 5'd24));
    // Clear fills blanks with the configured attribute and homes the cursor.
    send_request(make_req(REQ_CLEAR, 8'h00, 8'h00, 7'd40, 5'd12));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd127, 5'd31));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    drain_results();

    // Random phases, each under its own clear attribute; the first and third use the
    // top value and the reset value. Each phase opens with a clear so the attribute shows.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: attr_value = 8'hFF;
        2: attr_value = ATTR_RESET;
        default: attr_value = ATTR_W'($urandom_range(1, 254));
      endcase
      write_clear_attr(attr_value);
      send_request(make_req(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                            ATTR_W'($urandom_range(0, 255)),
                            COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31))));
      run_traffic(231);
      drain_results();
    end

    // Every result has arrived; give the block time to show any stray one.
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[text_console_writer_top] OK");
    end else begin
      $display("[text_console_writer_top] ERROR");
    end
    $finish;
  end

endmodule
